// ===== rtl/nonpreemptive_priority_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_assert.svh
// assertion macros for the scheduler checker
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// types and constants of the non-preemptive priority scheduler
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_PROCESSES_DEF = 16;

  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int PIDX_W = 4;
  localparam int TIME_W = 21;
  localparam int TOT_W  = 25;

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic [PRI_W-1:0] priority_level;
    logic             last_record;
  } nps_in_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TOT_W-1:0]  total_turnaround;
    logic [TOT_W-1:0]  total_waiting;
    logic              last_result;
  } nps_out_t;

  typedef struct packed {
    logic ld_we;
    logic run_clr;
    logic scan_rd;
    logic commit;
    logic o_tat;
    logic o_wt;
    logic o_load;
    logic o_last;
  } nps_cmd_t;

  typedef struct packed {
    logic found;
  } nps_sts_t;

endpackage

// ===== rtl/nps_ctrl.sv =====
// ----------------------------------------------------------------------------
// nps_ctrl
// sequencer for loading, selection scans and result delivery
// ----------------------------------------------------------------------------
module nps_ctrl #(
  parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF,
  parameter int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
  parameter int CNT_W = $clog2(MAX_PROCESSES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output nps_pkg::nps_cmd_t cmd,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [IDX_W-1:0]  rd_addr,
  input  nps_pkg::nps_sts_t sts
);
  import nps_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_TAIL   = 4'd2;
  localparam logic [3:0] S_COMMIT = 4'd3;
  localparam logic [3:0] S_ORD    = 4'd4;
  localparam logic [3:0] S_OTAT   = 4'd5;
  localparam logic [3:0] S_OWT    = 4'd6;
  localparam logic [3:0] S_OLD    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] ld_cnt_r, ld_cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] sel_cnt_r, sel_cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_acc;
  logic             run_go;
  logic             idx_last;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && (state_r == S_LOAD);
  assign run_go    = in_acc && (in_last || (ld_cnt_r == CNT_W'(MAX_PROCESSES - 1)));
  assign idx_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == n_r);
  assign wr_addr   = IDX_W'(ld_cnt_r);
  assign rd_addr   = idx_r;

  always_comb begin
    state_nxt   = state_r;
    ld_cnt_nxt  = ld_cnt_r;
    n_nxt       = n_r;
    sel_cnt_nxt = sel_cnt_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cmd.ld_we = 1'b1;
          if (run_go) begin
            cmd.run_clr = 1'b1;
            n_nxt       = ld_cnt_r + CNT_W'(1);
            ld_cnt_nxt  = '0;
            sel_cnt_nxt = '0;
            idx_nxt     = '0;
            state_nxt   = S_SCAN;
          end else begin
            ld_cnt_nxt = ld_cnt_r + CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (idx_last) begin
          state_nxt = S_TAIL;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_TAIL: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit  = 1'b1;
        sel_cnt_nxt = sel_cnt_r + CNT_W'(1);
        idx_nxt     = '0;
        if (!sts.found || (sel_cnt_nxt == n_r)) begin
          state_nxt = S_ORD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_ORD: begin
        state_nxt = S_OTAT;
      end
      S_OTAT: begin
        cmd.o_tat = 1'b1;
        state_nxt = S_OWT;
      end
      S_OWT: begin
        cmd.o_wt  = 1'b1;
        state_nxt = S_OLD;
      end
      S_OLD: begin
        cmd.o_load = 1'b1;
        cmd.o_last = idx_last;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (idx_last) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      ld_cnt_r  <= '0;
      n_r       <= '0;
      sel_cnt_r <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ld_cnt_r  <= ld_cnt_nxt;
      n_r       <= n_nxt;
      sel_cnt_r <= sel_cnt_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ===== rtl/nps_datapath.sv =====
// ----------------------------------------------------------------------------
// nps_datapath
// process record memories, selection compare, schedule clock and result math
// ----------------------------------------------------------------------------
module nps_datapath #(
  parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF,
  parameter int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nps_pkg::nps_cmd_t cmd,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [IDX_W-1:0]  rd_addr,
  input  nps_pkg::nps_in_t  in_data,
  output nps_pkg::nps_out_t out_data,
  output nps_pkg::nps_sts_t sts
);
  import nps_pkg::*;

  logic [ARR_W-1:0]  arr_mem [MAX_PROCESSES];
  logic [BUR_W-1:0]  bur_mem [MAX_PROCESSES];
  logic [PRI_W-1:0]  pri_mem [MAX_PROCESSES];
  logic [TIME_W-1:0] cmp_mem [MAX_PROCESSES];

  logic [ARR_W-1:0]  arr_q_r;
  logic [BUR_W-1:0]  bur_q_r;
  logic [PRI_W-1:0]  pri_q_r;
  logic [TIME_W-1:0] cmp_q_r;
  logic [IDX_W-1:0]  q_idx_r;
  logic              q_vld_r;

  logic [MAX_PROCESSES-1:0] done_r;
  logic [TIME_W-1:0]        clock_r;

  // best already-arrived candidate
  logic             ha_r;
  logic [PRI_W-1:0] ap_r;
  logic [IDX_W-1:0] ai_r;
  logic [BUR_W-1:0] ab_r;
  // earliest pending candidate
  logic             he_r;
  logic [ARR_W-1:0] ea_r;
  logic [PRI_W-1:0] ep_r;
  logic [IDX_W-1:0] ei_r;
  logic [BUR_W-1:0] eb_r;

  logic              pend;
  logic              arrived;
  logic              upd_a;
  logic              upd_e;
  logic              found;
  logic [IDX_W-1:0]  pick_idx;
  logic [TIME_W-1:0] start_time;
  logic [BUR_W-1:0]  pick_bur;
  logic [TIME_W-1:0] clock_nxt;

  logic [TIME_W-1:0] tat_r;
  logic [TIME_W-1:0] ct_r;
  logic [BUR_W-1:0]  bd_r;
  logic [TIME_W-1:0] wt_r;
  logic [TOT_W-1:0]  sum_tat_r;
  logic [TOT_W-1:0]  sum_wt_r, sum_wt_nxt;
  nps_out_t          out_r;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      arr_mem[wr_addr] <= in_data.arrival_time;
      bur_mem[wr_addr] <= in_data.burst_time;
      pri_mem[wr_addr] <= in_data.priority_level;
    end
    if (cmd.commit && found) begin
      cmp_mem[pick_idx] <= clock_nxt;
    end
    arr_q_r <= arr_mem[rd_addr];
    bur_q_r <= bur_mem[rd_addr];
    pri_q_r <= pri_mem[rd_addr];
    cmp_q_r <= cmp_mem[rd_addr];
    q_idx_r <= rd_addr;
  end

  // selection compare
  assign pend    = q_vld_r && !done_r[q_idx_r];
  assign arrived = (TIME_W'(arr_q_r) <= clock_r);
  assign upd_a   = pend && arrived && (!ha_r || (pri_q_r < ap_r));
  assign upd_e   = pend && (!he_r || (arr_q_r < ea_r) ||
                            ((arr_q_r == ea_r) && (pri_q_r < ep_r)));

  assign found      = ha_r || he_r;
  assign pick_idx   = ha_r ? ai_r : ei_r;
  assign start_time = ha_r ? clock_r : TIME_W'(ea_r);
  assign pick_bur   = ha_r ? ab_r : eb_r;
  assign clock_nxt  = start_time + TIME_W'(pick_bur);
  assign sts.found  = found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
      done_r  <= '0;
      clock_r <= '0;
      ha_r    <= 1'b0;
      he_r    <= 1'b0;
    end else begin
      q_vld_r <= cmd.scan_rd;
      if (cmd.run_clr) begin
        done_r  <= '0;
        clock_r <= '0;
        ha_r    <= 1'b0;
        he_r    <= 1'b0;
      end else if (cmd.commit) begin
        ha_r <= 1'b0;
        he_r <= 1'b0;
        if (found) begin
          clock_r          <= clock_nxt;
          done_r[pick_idx] <= 1'b1;
        end
      end else begin
        if (upd_a) begin
          ha_r <= 1'b1;
        end
        if (upd_e) begin
          he_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_a) begin
      ap_r <= pri_q_r;
      ai_r <= q_idx_r;
      ab_r <= bur_q_r;
    end
    if (upd_e) begin
      ea_r <= arr_q_r;
      ep_r <= pri_q_r;
      ei_r <= q_idx_r;
      eb_r <= bur_q_r;
    end
  end

  // result math
  assign sum_wt_nxt = sum_wt_r + TOT_W'(wt_r);

  always_ff @(posedge clk) begin
    if (cmd.run_clr) begin
      sum_tat_r <= '0;
      sum_wt_r  <= '0;
    end else begin
      if (cmd.o_wt) begin
        sum_tat_r <= sum_tat_r + TOT_W'(tat_r);
      end
      if (cmd.o_load) begin
        sum_wt_r <= sum_wt_nxt;
      end
    end
    if (cmd.o_tat) begin
      tat_r <= cmp_q_r - TIME_W'(arr_q_r);
      ct_r  <= cmp_q_r;
      bd_r  <= bur_q_r;
    end
    if (cmd.o_wt) begin
      wt_r <= tat_r - TIME_W'(bd_r);
    end
    if (cmd.o_load) begin
      out_r.process_index    <= PIDX_W'(rd_addr);
      out_r.completion_time  <= ct_r;
      out_r.turnaround_time  <= tat_r;
      out_r.waiting_time     <= wt_r;
      out_r.total_turnaround <= cmd.o_last ? sum_tat_r : '0;
      out_r.total_waiting    <= cmd.o_last ? sum_wt_nxt : '0;
      out_r.last_result      <= cmd.o_last;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// non-preemptive priority schedule over a loaded set of process records
// ----------------------------------------------------------------------------
// Records are taken one per cycle while the block is loading; the record
// marked last, or the one that fills the final slot, starts the run. A run
// over N records makes N selections, and each selection walks all N stored
// entries through the single read port of the record memories, one entry per
// cycle, then passes through a tail state and a commit state. Results then
// leave in load order, each worked out through the read, turnaround, waiting
// and load states and held while the output stalls, after which the block
// takes records again. No request is accepted during a run.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nps_pkg::nps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nps_pkg::nps_out_t out_data
);
  import nps_pkg::*;

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

  nps_cmd_t         cmd;
  nps_sts_t         sts;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  nps_ctrl #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_record),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .sts      (sts)
  );

  nps_datapath #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .in_data (in_data),
    .out_data(out_data),
    .sts     (sts)
  );

endmodule

// ===== rtl/nps_checker.sv =====
// ----------------------------------------------------------------------------
// nps_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "nonpreemptive_priority_scheduler_assert.svh"

module nps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input nps_pkg::nps_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input nps_pkg::nps_out_t out_data
);
  import nps_pkg::*;

  // stalled request held by the sender
  `NPS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // result held while stalled
  `NPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // no new request taken while results are pending
  `NPS_ASSERT_NOW(a_busy_out, out_valid, in_stall)

  // input stays stalled after a non-final result is taken
  `NPS_ASSERT_NEXT(a_more, out_valid && !out_stall && !out_data.last_result, in_stall)

  // totals show only on the final result
  `NPS_ASSERT_NOW(a_totals, out_valid && !out_data.last_result,
                  out_data.total_turnaround == '0 && out_data.total_waiting == '0)

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== dv/tb_nonpreemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler
// self-checking bench for the non-preemptive priority scheduler
// ----------------------------------------------------------------------------
// Sets of process records are staged in a queue and sent by a clocked driver
// with random gaps. When a set closes, an in-bench scheduler works out the
// schedule and queues one result per process. A clocked monitor stalls the
// result channel at random and compares every result, field by field, with
// the oldest queued one. A short directed part comes first, then random sets
// of mostly small size with content that forces contention, ties and idle time.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler;
  import nps_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int NPROC          = MAX_PROCESSES_DEF;
  localparam int RANDOM_ITEMS   = 250;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 50;

  typedef struct {
    nps_in_t rec;
    bit      drain;
  } staged_rec_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  nps_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  nps_out_t out_data;

  staged_rec_t record_q[$];
  nps_out_t    result_q[$];

  bit [15:0] proc_arrival [NPROC];
  bit [15:0] proc_burst   [NPROC];
  bit [7:0]  proc_prio    [NPROC];
  int        set_size  = 0;

  int staged_cnt = 0;
  int loaded_cnt = 0;
  int err_cnt    = 0;
  int tx_gap     = 0;
  int tx_calm    = 0;
  int rx_stall   = 0;
  int rx_calm    = 0;

  nonpreemptive_priority_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // mostly none or short idle spells, a few long ones, and calm stretches with none
  function automatic int idle_len(ref int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic schedule_set();
    bit [20:0] tick;
    bit [20:0] finish [NPROC];
    bit        done   [NPROC];
    bit [15:0] earliest;
    bit [20:0] tat;
    bit [20:0] wt;
    bit [24:0] tat_sum;
    bit [24:0] wt_sum;
    int        pick;
    nps_out_t  res;
    tick    = '0;
    tat_sum = '0;
    wt_sum  = '0;
    foreach (done[i]) done[i] = 1'b0;
    for (int k = 0; k < set_size; k++) begin
      earliest = 16'hFFFF;
      for (int i = 0; i < set_size; i++)
        if (!done[i] && proc_arrival[i] < earliest) earliest = proc_arrival[i];
      // nothing ready: jump to the earliest pending arrival
      if (tick < 21'(earliest)) tick = 21'(earliest);
      pick = -1;
      for (int i = 0; i < set_size; i++)
        if (!done[i] && 21'(proc_arrival[i]) <= tick &&
            (pick < 0 || proc_prio[i] < proc_prio[pick])) pick = i;
      tick         = tick + 21'(proc_burst[pick]);
      finish[pick] = tick;
      done[pick]   = 1'b1;
    end
    for (int i = 0; i < set_size; i++) begin
      tat     = finish[i] - 21'(proc_arrival[i]);
      wt      = tat - 21'(proc_burst[i]);
      tat_sum = tat_sum + 25'(tat);
      wt_sum  = wt_sum + 25'(wt);
      res.process_index    = PIDX_W'(i);
      res.completion_time  = finish[i];
      res.turnaround_time  = tat;
      res.waiting_time     = wt;
      res.last_result      = (i == set_size - 1);
      res.total_turnaround = res.last_result ? tat_sum : '0;
      res.total_waiting    = res.last_result ? wt_sum : '0;
      result_q.push_back(res);
    end
  endtask

  task automatic load_record(input nps_in_t rec);
    proc_arrival[set_size] = rec.arrival_time;
    proc_burst[set_size]   = rec.burst_time;
    proc_prio[set_size]    = rec.priority_level;
    set_size++;
    // a full store closes the set even without the last mark
    if (rec.last_record || set_size == NPROC) begin
      schedule_set();
      set_size = 0;
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    err_cnt++;
  endtask

  task automatic check_result(input nps_out_t want, input nps_out_t got);
    if (got.process_index !== want.process_index)
      report_field("process_index", 32'(want.process_index), 32'(got.process_index));
    if (got.completion_time !== want.completion_time)
      report_field("completion_time", 32'(want.completion_time),
                   32'(got.completion_time));
    if (got.turnaround_time !== want.turnaround_time)
      report_field("turnaround_time", 32'(want.turnaround_time),
                   32'(got.turnaround_time));
    if (got.waiting_time !== want.waiting_time)
      report_field("waiting_time", 32'(want.waiting_time), 32'(got.waiting_time));
    if (got.total_turnaround !== want.total_turnaround)
      report_field("total_turnaround", 32'(want.total_turnaround),
                   32'(got.total_turnaround));
    if (got.total_waiting !== want.total_waiting)
      report_field("total_waiting", 32'(want.total_waiting), 32'(got.total_waiting));
    if (got.last_result !== want.last_result)
      report_field("last_result", 32'(want.last_result), 32'(got.last_result));
  endtask

  task automatic stage(input bit [15:0] arr, input bit [15:0] bur, input bit [7:0] pri,
                       input bit last, input bit drain);
    staged_rec_t s;
    s.rec.arrival_time   = arr;
    s.rec.burst_time     = bur;
    s.rec.priority_level = pri;
    s.rec.last_record    = last;
    s.drain              = drain;
    record_q.push_back(s);
    staged_cnt++;
  endtask

  task automatic stage_random_set(input int size, input bit drain);
    int        flavor;
    bit [15:0] arr;
    bit [15:0] bur;
    bit [7:0]  pri;
    bit        last;
    for (int i = 0; i < size; i++) begin
      flavor = $urandom_range(0, 9);
      if (flavor < 6) begin
        // crowded: close arrivals, short bursts, many priority ties
        arr = 16'($urandom_range(0, 40));
        bur = 16'($urandom_range(0, 20));
        pri = 8'($urandom_range(0, 3));
      end else if (flavor < 8) begin
        arr = 16'($urandom_range(0, 400));
        bur = 16'($urandom_range(0, 100));
        pri = 8'($urandom_range(0, 255));
      end else begin
        arr = 16'($urandom);
        bur = 16'($urandom);
        pri = 8'($urandom);
      end
      if (i < size - 1) last = 1'b0;
      else if (size == NPROC) last = 1'($urandom_range(0, 1));
      else last = 1'b1;
      stage(arr, bur, pri, last, drain && i == 0);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        load_record(in_data);
        loaded_cnt++;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (record_q.size() > 0 &&
                   !(record_q[0].drain && result_q.size() > 0)) begin
        in_data  <= record_q[0].rec;
        in_valid <= 1'b1;
        void'(record_q.pop_front());
        tx_gap = idle_len(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          err_cnt++;
        end else begin
          check_result(result_q.pop_front(), out_data);
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_stall = idle_len(rx_calm);
      end
    end
  end

  initial begin
    int size;
    int roll;
    int set_no;
    // lone process, all zero: zero burst at tick zero
    stage(16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0);
    // lone process, all max: clock jumps to a late arrival
    stage(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
    // early low-priority job blocks, then a priority tie, then a zero burst
    stage(16'd5, 16'd3, 8'd2, 1'b0, 1'b0);
    stage(16'd0, 16'd10, 8'd7, 1'b0, 1'b0);
    stage(16'd2, 16'd0, 8'd2, 1'b1, 1'b0);
    // sixteen records with no last mark: the full store closes the set
    for (int i = 0; i < NPROC; i++)
      stage(16'(i * 16'h1111), 16'(16'hFFFF - i * 16'h1111),
            (i % 3 == 0) ? 8'h00 : 8'hFF, 1'b0, 1'b0);

    set_no = 0;
    while (staged_cnt < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) size = $urandom_range(1, 6);
      else if (roll < 92) size = $urandom_range(7, NPROC - 1);
      else size = NPROC;
      stage_random_set(size, set_no % 8 == 0);
      set_no++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (loaded_cnt < staged_cnt) @(posedge clk);
    while (result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_ctrl.sv
rtl/nps_datapath.sv
rtl/nonpreemptive_priority_scheduler.sv
rtl/nps_checker.sv
dv/tb_nonpreemptive_priority_scheduler.sv
